FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

FILE: sv/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared widths, register indexes, reset values and the CRC-4 helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbt_pkg;

    localparam int ID_W       = 15;
    localparam int THRESH_W   = 10;
    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int WORD_W     = 16;
    localparam int CRC_W      = 4;
    localparam int FRAME_W    = 21;
    localparam int POS_W      = 5;
    localparam int OUT_DATA_W = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_DEVICE_ID = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_INTERVAL  = 2'd2;

    localparam logic [ID_W-1:0]       RESET_ID       = 15'd104;
    localparam logic [THRESH_W-1:0]   RESET_THRESH   = 10'd262;
    localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 16'd225;
    localparam logic [INTERVAL_W-1:0] COUNT_MAX      = 16'hFFFF;

    localparam logic [POS_W-1:0] FRAME_BITS = 5'd21;
    localparam logic [POS_W-1:0] LAST_POS   = 5'd20;

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [CRC_W-1:0]   crc_t;

    // x^i mod (x^4 + x^2 + x + 1) for every bit of the 16-bit word
    localparam crc_t [WORD_W-1:0] CRC_COL = '{
        4'h2, 4'h1, 4'hB, 4'hE, 4'h7, 4'h8, 4'h4, 4'h2,
        4'h1, 4'hB, 4'hE, 4'h7, 4'h8, 4'h4, 4'h2, 4'h1
    };

    // remainder is linear in the word: XOR of the columns of the set bits
    function automatic crc_t crc4_of(input word_t word);
        crc_t acc;
        acc = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (word[i])
            begin
                acc = acc ^ CRC_COL[i];
            end
        end
        return acc;
    endfunction

endpackage

FILE: sv/mbt_frame_build.sv
// ----------------------------------------------------------------------------
// mbt_frame_build
// Assembles preamble, flag, device id and CRC-4 into one 21-bit frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbt_frame_build (
    input  logic [mbt_pkg::ID_W-1:0] device_id,
    input  logic                     low_volt,
    output mbt_pkg::frame_t          frame
);
    import mbt_pkg::*;

    word_t word;

    assign word  = {low_volt, device_id};
    assign frame = {1'b1, word, crc4_of(word)};

endmodule

FILE: sv/manchester_beacon_crc4_transmitter_core.sv
// ----------------------------------------------------------------------------
// manchester_beacon_crc4_transmitter_core
// Periodic Manchester beacon with a CRC-4 protected id frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one word per tick. s_tuser is the tick kind
//   (0 slow sleep tick, 1 half-bit tick), s_tdata the supply sample.
//   Output stream (m_*): one word per input word, in order. m_tdata carries
//   the LED level and the sending flag; m_tlast marks the tick that closes
//   a frame.
//   Config port: cfg_we/cfg_addr/cfg_wdata writes device id (0), voltage
//   threshold (1) or sleep interval (2); write only while idle.
// Timing:
//   m_tvalid is set in the cycle after acceptance. Unless the output stalls,
//   one word can be taken every cycle: all per-tick work (frame build, CRC,
//   bit select) is one combinational pass into state and output registers.
// Reset:
//   Registers take their defaults; the sleep count starts at the interval,
//   so the first tick after reset launches a frame.
// Stall:
//   The output register holds its word while m_tready is low; s_tready then
//   drops, so no word is lost or dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module manchester_beacon_crc4_transmitter_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_we,
    input  logic [mbt_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mbt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,   // [SAMPLE_BITS-1:0] voltage_sample
    input  logic                               s_tuser,   // [0] mode
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mbt_pkg::OUT_DATA_W-1:0]     m_tdata,   // [0] led_lit, [1] sending
    output logic                               m_tlast    // frame_done
);
    import mbt_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    // configuration
    logic [ID_W-1:0]       device_id_reg;
    logic [THRESH_W-1:0]   threshold_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    // transmitter state
    logic [INTERVAL_W-1:0]  count_reg, count_next;
    logic                   busy_reg, busy_next;
    frame_t                 frame_reg, frame_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   half_reg, half_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                   led_reg, led_next;
    logic                   done_next;

    // output register
    logic                   out_valid_reg;
    logic                   out_led_reg;
    logic                   out_busy_reg;
    logic                   out_done_reg;

    logic                   accept;
    logic                   start;
    logic                   low_volt;
    frame_t                 built_frame;
    frame_t                 frame_e;
    frame_t                 bit_mask;
    frame_t                 lowest;
    logic                   busy_e;
    logic [POS_W-1:0]       pos_e;
    logic                   half_e;
    logic [INTERVAL_W-1:0]  count_e;
    logic                   led_e;
    logic                   cur_bit;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign low_volt = CMP_W'(sample_reg) > CMP_W'(threshold_reg);

    mbt_frame_build u_frame_build (
        .device_id (device_id_reg),
        .low_volt  (low_volt),
        .frame     (built_frame)
    );

    // a frame starts at the head of the tick when idle and the wait is over
    assign start = !busy_reg && (count_reg >= interval_reg);

    always_comb
    begin
        busy_e  = busy_reg || start;
        frame_e = start ? built_frame : frame_reg;
        pos_e   = start ? '0 : pos_reg;
        half_e  = start ? 1'b0 : half_reg;
        count_e = start ? '0 : count_reg;
        led_e   = start ? 1'b0 : led_reg;

        bit_mask = frame_t'(1) << (LAST_POS - pos_e);
        cur_bit  = |(frame_e & bit_mask);
        lowest   = frame_e & (~frame_e + frame_t'(1));

        busy_next   = busy_e;
        frame_next  = frame_e;
        pos_next    = pos_e;
        half_next   = half_e;
        count_next  = count_e;
        led_next    = led_e;
        sample_next = sample_reg;
        done_next   = 1'b0;

        if (!s_tuser)
        begin
            // slow tick: saturating sleep count
            if (count_e != COUNT_MAX)
            begin
                count_next = count_e + INTERVAL_W'(1);
            end
        end
        else if (busy_e)
        begin
            if (pos_e < FRAME_BITS)
            begin
                led_next = cur_bit ^ half_e;
                if (lowest == bit_mask)
                begin
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                end
                if (half_e)
                begin
                    pos_next  = pos_e + POS_W'(1);
                    half_next = 1'b0;
                end
                else
                begin
                    half_next = 1'b1;
                end
            end
            else
            begin
                // trailing tick: LED off, frame closed
                led_next   = 1'b0;
                busy_next  = 1'b0;
                count_next = '0;
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= RESET_ID;
            threshold_reg <= RESET_THRESH;
            interval_reg  <= RESET_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_IDX_DEVICE_ID: device_id_reg <= cfg_wdata[ID_W-1:0];
                CFG_IDX_THRESHOLD: threshold_reg <= cfg_wdata[THRESH_W-1:0];
                CFG_IDX_INTERVAL:  interval_reg  <= cfg_wdata[INTERVAL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= RESET_INTERVAL;
            busy_reg   <= 1'b0;
            frame_reg  <= '0;
            pos_reg    <= '0;
            half_reg   <= 1'b0;
            sample_reg <= '0;
            led_reg    <= 1'b0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            busy_reg   <= busy_next;
            frame_reg  <= frame_next;
            pos_reg    <= pos_next;
            half_reg   <= half_next;
            sample_reg <= sample_next;
            led_reg    <= led_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_led_reg  <= led_next;
            out_busy_reg <= busy_next;
            out_done_reg <= done_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W-2)'(0), out_busy_reg, out_led_reg};
    assign m_tlast  = out_done_reg;

endmodule

FILE: sv/mbt_checker.sv
// ----------------------------------------------------------------------------
// mbt_checker
// Port-level checks on the beacon transmitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mbt_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import mbt_pkg::*;

    // stalled word stays presented
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output word dropped")

    // input side only waits on a full, stalled output register
    `ASSERT_CLK(a_ready_follow, s_tready == (!m_tvalid || m_tready), "s_tready out of step")

    // closing tick: no longer sending and LED dark
    `ASSERT_IMPL(a_done_idle, m_tvalid && m_tlast, !m_tdata[1] && !m_tdata[0], "bad frame end")

    // LED only lit inside a frame
    `ASSERT_IMPL(a_led_busy, m_tvalid && m_tdata[0], m_tdata[1], "LED lit while idle")

endmodule

bind manchester_beacon_crc4_transmitter_core mbt_checker u_mbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Manchester beacon transmitter core.
// A short directed run right after reset checks the first half-bits of
// the default frame by hand. Random phases follow, each with its own id,
// threshold and interval: slow and half-bit ticks, with stalls on both
// streams. Every output word is checked against a cycle-free model of the
// beacon kept in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import mbt_pkg::*;

    // tick kinds carried in s_tuser
    localparam logic TICK_SLOW = 1'b0;
    localparam logic TICK_HALF = 1'b1;

    localparam int         SAMPLE_W    = 10;
    localparam int         FRAME_LEN   = 21;     // bits per frame, preamble included
    localparam logic [4:0] CRC4_POLY   = 5'h17;  // x^4 + x^2 + x + 1
    localparam int         STALL_LIMIT = 4000;   // cycles with no word moving

    // one output word as fields
    typedef struct packed {
        logic led;
        logic sending;
        logic done;
    } tick_result_t;

    // directed stimulus row; want is used only when typed is set
    typedef struct packed {
        logic             mode;
        logic [9:0]       reading;
        logic             typed;
        tick_result_t     want;
    } drill_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // [9:0] voltage_sample
    logic                  s_tuser   = 1'b0; // [0] mode
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [0] led_lit, [1] sending
    logic                  m_tlast;          // frame_done

    always #10 clk = ~clk;

    manchester_beacon_crc4_transmitter_core #(
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // Beacon model state (bc_*), registers first
    // ------------------------------------------------------------------------
    logic [ID_W-1:0]       bc_dev_id   = RESET_ID;
    logic [THRESH_W-1:0]   bc_thresh   = RESET_THRESH;
    logic [INTERVAL_W-1:0] bc_interval = RESET_INTERVAL;
    // count starts at the interval so the first tick launches a frame
    logic [INTERVAL_W-1:0] bc_count    = RESET_INTERVAL;
    logic                  bc_busy     = 1'b0;
    logic [FRAME_W-1:0]    bc_frame    = '0;
    logic [4:0]            bc_pos      = '0;
    logic                  bc_second   = 1'b0;
    logic [9:0]            bc_latched  = '0;
    logic                  bc_led      = 1'b0;

    tick_result_t predicted_outputs [$];
    int           mismatch_count = 0;
    int           src_idle_pct   = 20;
    int           snk_idle_pct   = 88;
    int           idle_cycles    = 0;

    // Directed words right after reset. Frame for id 104, flag clear:
    // 1 | 0x0068 | crc 0xD, so it opens with bit 1 then bit 0.
    drill_row_t drill_rows [25] = '{
        '{TICK_HALF, 10'h000, 1'b1, '{1'b1, 1'b1, 1'b0}},  // launch, first half of 1
        '{TICK_HALF, 10'h3FF, 1'b1, '{1'b0, 1'b1, 1'b0}},  // inverse half
        '{TICK_SLOW, 10'h3FF, 1'b1, '{1'b0, 1'b1, 1'b0}},  // slow tick holds LED
        '{TICK_HALF, 10'h155, 1'b1, '{1'b0, 1'b1, 1'b0}},  // bit 0, first half
        '{TICK_HALF, 10'h2AA, 1'b1, '{1'b1, 1'b1, 1'b0}},  // bit 0, inverse
        '{TICK_SLOW, 10'h000, 1'b0, '0},
        '{TICK_HALF, 10'h3FF, 1'b0, '0},
        '{TICK_HALF, 10'h000, 1'b0, '0},
        '{TICK_SLOW, 10'h1FF, 1'b0, '0},
        '{TICK_SLOW, 10'h200, 1'b0, '0},
        '{TICK_HALF, 10'h106, 1'b0, '0},
        '{TICK_HALF, 10'h107, 1'b0, '0},
        '{TICK_HALF, 10'h105, 1'b0, '0},
        '{TICK_HALF, 10'h001, 1'b0, '0},
        '{TICK_SLOW, 10'h3FE, 1'b0, '0},
        '{TICK_HALF, 10'h0F0, 1'b0, '0},
        '{TICK_HALF, 10'h30F, 1'b0, '0},
        '{TICK_HALF, 10'h3FF, 1'b0, '0},
        '{TICK_HALF, 10'h000, 1'b0, '0},
        '{TICK_SLOW, 10'h2AA, 1'b0, '0},
        '{TICK_HALF, 10'h155, 1'b0, '0},
        '{TICK_HALF, 10'h3FF, 1'b0, '0},
        '{TICK_HALF, 10'h000, 1'b0, '0},
        '{TICK_HALF, 10'h3FF, 1'b0, '0},
        '{TICK_HALF, 10'h000, 1'b0, '0}
    };

    // word mod x^4 + x^2 + x + 1 by long division
    function automatic logic [3:0] crc4_remainder(input logic [15:0] word_in);
        logic [15:0] rem;
        rem = word_in;
        for (int b = 15; b >= 4; b--)
        begin
            if (rem[b])
            begin
                rem[b -: 5] = rem[b -: 5] ^ CRC4_POLY;
            end
        end
        return rem[3:0];
    endfunction

    // One accepted tick through the beacon model.
    task automatic advance_beacon(input logic mode, input logic [9:0] reading,
                                  output tick_result_t res);
        logic               flag;
        logic [15:0]        id_word;
        logic [FRAME_W-1:0] bit_mask;
        logic [FRAME_W-1:0] lowest;
        logic               done;
        done = 1'b0;
        // frame launch is checked before the tick itself is applied
        if (!bc_busy && bc_count >= bc_interval)
        begin
            flag      = bc_latched > bc_thresh;
            id_word   = {flag, bc_dev_id};
            bc_frame  = {1'b1, id_word, crc4_remainder(id_word)};
            bc_pos    = '0;
            bc_second = 1'b0;
            bc_count  = '0;
            bc_led    = 1'b0;
            bc_busy   = 1'b1;
        end
        if (mode == TICK_SLOW)
        begin
            if (bc_count != COUNT_MAX)
            begin
                bc_count = bc_count + 1'b1;
            end
        end
        else if (bc_busy)
        begin
            if (bc_pos < FRAME_LEN)
            begin
                bit_mask = '0;
                bit_mask[FRAME_LEN - 1 - bc_pos] = 1'b1;
                lowest   = bc_frame & (~bc_frame + 1'b1);
                bc_led   = ((bc_frame & bit_mask) != '0) ^ bc_second;
                // sample is taken on both halves of the lowest set bit
                if (lowest == bit_mask)
                begin
                    bc_latched = reading;
                end
                if (bc_second)
                begin
                    bc_pos    = bc_pos + 1'b1;
                    bc_second = 1'b0;
                end
                else
                begin
                    bc_second = 1'b1;
                end
            end
            else
            begin
                // tick after the last half closes the frame
                bc_led   = 1'b0;
                bc_busy  = 1'b0;
                bc_count = '0;
                done     = 1'b1;
            end
        end
        res = '{bc_led, bc_busy, done};
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Present one input word, wait for the handshake, log the expectation.
    // Leaves s_tvalid high; the caller either sends again or drops it.
    task automatic feed_tick(input logic mode, input logic [9:0] reading,
                             input logic typed, input tick_result_t want);
        tick_result_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {6'b0, reading};
        do
            @(posedge clk);
        while (!s_tready);
        advance_beacon(mode, reading, pred);
        predicted_outputs.push_back(typed ? want : pred);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (predicted_outputs.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Reprogram all three registers once the stream is empty.
    task automatic program_regs(input logic [15:0] id_word,
                                input logic [15:0] thr_word,
                                input logic [15:0] ivl_word);
        wait_drained();
        repeat (3) @(posedge clk);  // registered output, plus margin
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IDX_DEVICE_ID;
        cfg_wdata <= id_word;
        @(posedge clk);
        bc_dev_id = id_word[ID_W-1:0];
        cfg_addr  <= CFG_IDX_THRESHOLD;
        cfg_wdata <= thr_word;
        @(posedge clk);
        bc_thresh = thr_word[THRESH_W-1:0];
        cfg_addr  <= CFG_IDX_INTERVAL;
        cfg_wdata <= ivl_word;
        @(posedge clk);
        bc_interval = ivl_word;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Readings lean on the extremes and on the threshold edge so the
    // low-voltage flag goes both ways.
    function automatic logic [9:0] pick_reading();
        case ($urandom_range(9))
            0:       return 10'h000;
            1:       return 10'h3FF;
            2:       return bc_thresh;
            3:       return bc_thresh + 1'b1;
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    // Any tick mix is a legal sequence; half-bit ticks dominate so frames
    // run to completion and the sample latch gets exercised.
    task automatic run_random(input int count);
        logic mode;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2 || $urandom_range(149) == 0)
            begin
                wait_drained();
            end
            mode = ($urandom_range(99) < 65) ? TICK_HALF : TICK_SLOW;
            feed_tick(mode, pick_reading(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random backpressure and field checks
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : check_outputs
        tick_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word tdata=%h tlast=%b",
                                          m_tdata, m_tlast));
            end
            else
            begin
                want = predicted_outputs.pop_front();
                if (m_tdata[0] !== want.led)
                begin
                    report_mismatch($sformatf("led_lit want %b got %b",
                                              want.led, m_tdata[0]));
                end
                if (m_tdata[1] !== want.sending)
                begin
                    report_mismatch($sformatf("sending want %b got %b",
                                              want.sending, m_tdata[1]));
                end
                if (m_tlast !== want.done)
                begin
                    report_mismatch($sformatf("frame_done want %b got %b",
                                              want.done, m_tlast));
                end
            end
        end
    end

    // Watchdog: any word moving on either stream resets the count.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed, default registers, sender 20% / receiver 88% idle
        for (int r = 0; r < 25; r++)
        begin
            feed_tick(drill_rows[r].mode, drill_rows[r].reading,
                      drill_rows[r].typed, drill_rows[r].want);
        end

        // short interval; junk in the upper id bit
        program_regs(16'($urandom), 16'($urandom), 16'd1);
        run_random(350);

        // max id, zero threshold (flag set by any nonzero sample)
        program_regs(16'hFFFF, 16'hFC00, 16'd3);
        src_idle_pct = 88;
        snk_idle_pct = 20;
        run_random(350);

        // zero id, max threshold (flag never set), zero interval:
        // frames run back to back
        program_regs(16'h8000, 16'h03FF, 16'h0000);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(150);

        // long interval: finish any open frame, sleep past the count,
        // then send the frame it launches
        program_regs(16'($urandom), 16'($urandom), 16'd250);
        for (int i = 0; i < 60; i++)
        begin
            feed_tick(TICK_HALF, pick_reading(), 1'b0, '0);
        end
        for (int i = 0; i < 255; i++)
        begin
            feed_tick(TICK_SLOW, pick_reading(), 1'b0, '0);
        end
        for (int i = 0; i < 60; i++)
        begin
            feed_tick(TICK_HALF, pick_reading(), 1'b0, '0);
        end

        program_regs(16'($urandom), 16'($urandom), 16'($urandom_range(40, 1)));
        run_random(150);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/mbt_pkg.sv
sv/mbt_frame_build.sv
sv/manchester_beacon_crc4_transmitter_core.sv
sv/mbt_checker.sv
test/tb.sv
